@@ hw/rtl/xtee_pkg.sv @@
// xtee_pkg: shared types, constants and byte tables for the xml text escape encoder
// no dependencies

package xtee_pkg;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    KIND_PLAIN,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_APOS,
    KIND_HEX
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_LL    = 8'h6c;
  localparam logic [7:0] CH_LM    = 8'h6d;
  localparam logic [7:0] CH_LO    = 8'h6f;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LQ    = 8'h71;
  localparam logic [7:0] CH_LS    = 8'h73;
  localparam logic [7:0] CH_LT_T  = 8'h74;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_LX    = 8'h78;

  function automatic kind_t classify(input logic [7:0] b);
    kind_t k;
    case (b)
      CH_AMP:  k = KIND_AMP;
      CH_LT:   k = KIND_LT;
      CH_GT:   k = KIND_GT;
      CH_QUOT: k = KIND_QUOT;
      CH_APOS: k = KIND_APOS;
      default: begin
        if (b inside {[CH_SPACE:CH_TILDE]}) k = KIND_PLAIN;
        else k = KIND_HEX;
      end
    endcase
    return k;
  endfunction

  function automatic logic [2:0] run_len(input kind_t k);
    logic [2:0] n;
    case (k)
      KIND_PLAIN: n = 3'd1;
      KIND_AMP:   n = 3'd5;
      KIND_LT:    n = 3'd4;
      KIND_GT:    n = 3'd4;
      default:    n = 3'd6;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = CH_ZERO + {4'h0, d};
    else c = CH_LA + {4'h0, d} - 8'd10;
    return c;
  endfunction

  function automatic logic [7:0] run_char(input item_t it, input logic [2:0] idx);
    logic [7:0] c;
    c = CH_AMP;
    case (it.kind)
      KIND_PLAIN: c = it.data;
      KIND_AMP: begin
        case (idx)
          3'd1:    c = CH_LA;
          3'd2:    c = CH_LM;
          3'd3:    c = CH_LP;
          3'd4:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      KIND_LT, KIND_GT: begin
        case (idx)
          3'd1:    c = (it.kind == KIND_LT) ? CH_LL : CH_LG;
          3'd2:    c = CH_LT_T;
          3'd3:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          3'd1:    c = CH_LQ;
          3'd2:    c = CH_LU;
          3'd3:    c = CH_LO;
          3'd4:    c = CH_LT_T;
          3'd5:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      KIND_APOS: begin
        case (idx)
          3'd1:    c = CH_LA;
          3'd2:    c = CH_LP;
          3'd3:    c = CH_LO;
          3'd4:    c = CH_LS;
          3'd5:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
      default: begin
        case (idx)
          3'd1:    c = CH_HASH;
          3'd2:    c = CH_LX;
          3'd3:    c = hex_char(it.data[7:4]);
          3'd4:    c = hex_char(it.data[3:0]);
          3'd5:    c = CH_SEMI;
          default: c = CH_AMP;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

@@ hw/rtl/xtee_front.sv @@
// xtee_front: input register stage that accepts raw bytes and classifies them
// depends on xtee_pkg

module xtee_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  output logic            push_valid,
  input  logic            push_ready,
  output xtee_pkg::item_t push_item
);

  logic            valid_r, valid_nxt;
  xtee_pkg::item_t item_r;

  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) valid_nxt = in_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.kind <= xtee_pkg::classify(in_byte);
      item_r.data <= in_byte;
    end
  end

endmodule

@@ hw/rtl/xtee_queue.sv @@
// xtee_queue: small fifo of classified items between front and back
// depends on xtee_pkg

module xtee_queue #(
  parameter int DEPTH = xtee_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  xtee_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output xtee_pkg::item_t pop_item
);

  localparam int AW = $clog2(DEPTH);

  xtee_pkg::item_t mem [DEPTH];
  logic [AW:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW:0]     rd_ptr_r, rd_ptr_nxt;
  logic            full, empty, push, pop;

  assign full  = (wr_ptr_r[AW] != rd_ptr_r[AW]) && (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign empty = (wr_ptr_r == rd_ptr_r);
  assign push_ready = !full;
  assign pop_valid  = !empty;
  assign pop_item   = mem[rd_ptr_r[AW-1:0]];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r[AW-1:0]] <= push_item;
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r - rd_ptr_r) <= DEPTH[AW:0] || (wr_ptr_r - rd_ptr_r) == DEPTH[AW:0])
    else $error("queue fill count beyond depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full)
    else $error("queue lost an entry without a pop");

endmodule

@@ hw/rtl/xtee_back.sv @@
// xtee_back: sequencer that expands each queued item into its escaped byte run
// depends on xtee_pkg; drives the registered output channel

module xtee_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  xtee_pkg::item_t pop_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       load, last_here;

  assign load      = (!valid_r || out_ready) && pop_valid;
  assign last_here = (idx_r == xtee_pkg::run_len(pop_item.kind) - 3'd1);
  assign pop_ready = (!valid_r || out_ready) && last_here;

  assign out_valid    = valid_r;
  assign out_byte     = byte_r;
  assign out_run_last = last_r;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (!valid_r || out_ready) valid_nxt = pop_valid;
    if (load) idx_nxt = last_here ? 3'd0 : idx_r + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 3'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= xtee_pkg::run_char(pop_item, idx_r);
      last_r <= last_here;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= 3'd5)
    else $error("run index out of range");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> (valid_r && last_r))
    else $error("item released before its last byte");

endmodule

@@ hw/rtl/xml_text_escape_encoder_top.sv @@
// Printable bytes pass at one item per cycle in and one byte per cycle out while out_ready is
// high. A byte that needs escaping yields a run of four to six output bytes (one per cycle while
// out_ready is high), at the rate of the back-end sequencer, which emits them from the head of
// the item queue. The front register and the QUEUE_DEPTH-entry queue keep taking input during a
// run until the queue fills, and out_run_last marks each run's final byte.
// depends on xtee_pkg, xtee_front, xtee_queue, xtee_back

module xml_text_escape_encoder_top #(
  parameter int QUEUE_DEPTH = xtee_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  logic            push_valid, push_ready, pop_valid, pop_ready;
  xtee_pkg::item_t push_item, pop_item;

  xtee_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  xtee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  xtee_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_item     (pop_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule
